[design/icds_pkg.sv]
// Package for the instruction-count frequency scheduler.
// Item types, register indexes, opcodes and reset values.
// No dependencies.
package icds_pkg;

    localparam int CFG_DW    = 40;
    localparam int CFG_IW    = 3;
    localparam int FREQ_W    = 16;
    localparam int TARGET_W  = 40;
    localparam int TOTAL_W   = 48;
    localparam int ADDR_W    = 48;
    localparam int TID_W     = 6;
    localparam int CNT_W     = 16;
    localparam int MAX_TIDS  = 64;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_FREQ_A     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_FREQ_B     = 3'd1;
    localparam logic [CFG_IW-1:0] REG_FREQ_C     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_TARGET_A   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_TARGET_B   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_TARGET_C   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_START_FREQ = 3'd6;

    // Event opcodes
    localparam logic [1:0] OP_RETIRE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Schedule positions
    localparam logic [1:0] POS_A = 2'd0;
    localparam logic [1:0] POS_B = 2'd1;
    localparam logic [1:0] POS_C = 2'd2;

    // Reset values
    localparam logic [FREQ_W-1:0]   RST_FREQ_A     = 16'd1995;
    localparam logic [FREQ_W-1:0]   RST_FREQ_B     = 16'd1330;
    localparam logic [FREQ_W-1:0]   RST_FREQ_C     = 16'd2660;
    localparam logic [TARGET_W-1:0] RST_TARGET_A   = 40'd600000000;
    localparam logic [TARGET_W-1:0] RST_TARGET_B   = 40'd200000000;
    localparam logic [TARGET_W-1:0] RST_TARGET_C   = 40'd1400000000;
    localparam logic [FREQ_W-1:0]   RST_START_FREQ = 16'd1000;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TID_W-1:0]  thread_num;
        logic [CNT_W-1:0]  insn_count;
        logic [ADDR_W-1:0] prog_addr;
    } icds_req_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_now;
        logic              set_valid;
        logic [TID_W-1:0]  set_thread;
        logic              phase_change;
        logic [ADDR_W-1:0] phase_addr;
    } icds_rsp_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq_a;
        logic [FREQ_W-1:0]   freq_b;
        logic [FREQ_W-1:0]   freq_c;
        logic [TARGET_W-1:0] target_a;
        logic [TARGET_W-1:0] target_b;
        logic [TARGET_W-1:0] target_c;
    } icds_cfg_t;

    // Start-frequency write, seen by the core to reload the current frequency
    typedef struct packed {
        logic              load;
        logic [FREQ_W-1:0] freq;
    } icds_freq_load_t;

endpackage

[design/icds_if.sv]
// Valid/ready channel interfaces for scheduler events and results.
// Depends on icds_pkg.
interface icds_req_if;
    import icds_pkg::*;

    logic      valid;
    logic      ready;
    icds_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface icds_rsp_if;
    import icds_pkg::*;

    logic      valid;
    logic      ready;
    icds_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/icds_cfg.sv]
// Configuration register file for the schedule table.
// Depends on icds_pkg.
module icds_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [icds_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [icds_pkg::CFG_DW-1:0]       cfg_data,
    output icds_pkg::icds_cfg_t               cfg,
    output icds_pkg::icds_freq_load_t         freq_load
);
    import icds_pkg::*;

    icds_cfg_t cfg_reg;
    icds_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FREQ_A:   cfg_next.freq_a   = cfg_data[FREQ_W-1:0];
                REG_FREQ_B:   cfg_next.freq_b   = cfg_data[FREQ_W-1:0];
                REG_FREQ_C:   cfg_next.freq_c   = cfg_data[FREQ_W-1:0];
                REG_TARGET_A: cfg_next.target_a = cfg_data[TARGET_W-1:0];
                REG_TARGET_B: cfg_next.target_b = cfg_data[TARGET_W-1:0];
                REG_TARGET_C: cfg_next.target_c = cfg_data[TARGET_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_a   <= RST_FREQ_A;
            cfg_reg.freq_b   <= RST_FREQ_B;
            cfg_reg.freq_c   <= RST_FREQ_C;
            cfg_reg.target_a <= RST_TARGET_A;
            cfg_reg.target_b <= RST_TARGET_B;
            cfg_reg.target_c <= RST_TARGET_C;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg            = cfg_reg;
    assign freq_load.load = cfg_wr_en && (cfg_index == REG_START_FREQ);
    assign freq_load.freq = cfg_data[FREQ_W-1:0];

endmodule

[design/icds_core.sv]
// Scheduler state and per-item logic: count, budget compare, schedule step,
// thread active/pending vectors. Depends on icds_pkg.
module icds_core #(
    parameter int THREADS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  icds_pkg::icds_req_t        item,
    input  icds_pkg::icds_cfg_t        cfg,
    input  icds_pkg::icds_freq_load_t  freq_load,
    output icds_pkg::icds_rsp_t        result
);
    import icds_pkg::*;

    // Thread numbers are TID_W bits wide, so at most MAX_TIDS threads are reachable
    localparam int TSTORE = (THREADS < MAX_TIDS) ? THREADS : MAX_TIDS;
    localparam int IDXW   = (TSTORE > 1) ? $clog2(TSTORE) : 1;

    logic [TOTAL_W-1:0]  total_reg,  total_next;
    logic [TARGET_W-1:0] budget_reg, budget_next;
    logic [FREQ_W-1:0]   freq_reg,   freq_next;
    logic [1:0]          pos_reg,    pos_next;
    logic [TSTORE-1:0]   active_reg, active_next;
    logic [TSTORE-1:0]   pending_reg, pending_next;

    logic              in_range;
    logic [IDXW-1:0]   idx;
    logic              is_main;
    logic              adv;
    logic              pend_hit;
    logic              set_vld;
    logic [TSTORE-1:0] non_main;

    assign in_range = (32'(item.thread_num) < THREADS);
    assign idx      = item.thread_num[IDXW-1:0];
    assign is_main  = (item.thread_num == '0);
    assign non_main = ~TSTORE'(1);
    assign adv      = (item.opcode == OP_RETIRE) && is_main
                      && (total_reg > {{(TOTAL_W-TARGET_W){1'b0}}, budget_reg});

    always_comb
    begin
        total_next   = total_reg;
        budget_next  = budget_reg;
        freq_next    = freq_reg;
        pos_next     = pos_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        pend_hit     = 1'b0;
        set_vld      = 1'b0;

        if (adv)
        begin
            case (pos_reg)
                POS_B:
                begin
                    freq_next   = cfg.freq_b;
                    budget_next = cfg.target_b;
                end
                POS_C:
                begin
                    freq_next   = cfg.freq_c;
                    budget_next = cfg.target_c;
                end
                default:
                begin
                    freq_next   = cfg.freq_a;
                    budget_next = cfg.target_a;
                end
            endcase
            pending_next = pending_reg | (active_reg & non_main);
            pos_next     = (pos_reg >= POS_C) ? POS_A : pos_reg + 2'd1;
        end

        case (item.opcode)
            OP_RETIRE:
            begin
                if (is_main)
                begin
                    total_next = (adv ? '0 : total_reg) + TOTAL_W'(item.insn_count);
                end
                if (in_range && pending_next[idx])
                begin
                    pend_hit          = 1'b1;
                    pending_next[idx] = 1'b0;
                end
                set_vld = adv || pend_hit;
            end
            OP_START:
            begin
                if (in_range)
                begin
                    active_next[idx] = 1'b1;
                    set_vld          = 1'b1;
                end
            end
            OP_FINISH:
            begin
                if (in_range)
                begin
                    active_next[idx] = 1'b0;
                end
            end
            default:
            begin
                set_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            budget_reg  <= RST_TARGET_C;
            freq_reg    <= RST_START_FREQ;
            pos_reg     <= POS_A;
            active_reg  <= '0;
            pending_reg <= '0;
        end
        else if (step)
        begin
            total_reg   <= total_next;
            budget_reg  <= budget_next;
            freq_reg    <= freq_next;
            pos_reg     <= pos_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
        end
        else if (freq_load.load)
        begin
            freq_reg <= freq_load.freq;
        end
    end

    assign result.freq_now     = freq_next;
    assign result.set_valid    = set_vld;
    assign result.set_thread   = set_vld ? item.thread_num : '0;
    assign result.phase_change = adv;
    assign result.phase_addr   = adv ? item.prog_addr : '0;

endmodule

[design/instruction_count_dvfs_scheduler_top.sv]
// Top level of the instruction-count frequency scheduler.
// Depends on icds_pkg, icds_if, icds_cfg and icds_core.
//
// Usage:
//   req carries one event item (opcode, thread_num, insn_count, prog_addr);
//   rsp returns exactly one result item per event, in order. Both channels
//   use valid/ready; an item moves on a clock edge with both high.
//   The cfg port writes one schedule register per cycle with cfg_wr_en high;
//   write only while no event is in flight. Writing start_freq also loads
//   the current frequency.
// Path: an accepted request goes to the input register, then its result
//   to the result register. Throughput: one item per cycle while rsp.ready
//   is high; the budget compare and 48-bit count add sit between the two registers.
// Stall: while rsp.ready is low the result register holds and the input
//   register fills, then req.ready drops. No item is lost or repeated.
// Reset: rst_n clears both valid flags, count and thread vectors, restores
//   the register defaults, budget to target c and frequency to start_freq.
module instruction_count_dvfs_scheduler_top #(
    parameter int THREADS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    icds_req_if.sink                     req,
    icds_rsp_if.source                   rsp,
    input  logic                         cfg_wr_en,
    input  logic [icds_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [icds_pkg::CFG_DW-1:0]  cfg_data
);
    import icds_pkg::*;

    icds_req_t       in_reg;
    logic            in_vld_reg, in_vld_next;
    icds_rsp_t       out_reg;
    logic            out_vld_reg, out_vld_next;
    icds_rsp_t       result;
    icds_cfg_t       cfg;
    icds_freq_load_t freq_load;
    logic            accept;
    logic            step;

    assign step         = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready    = !in_vld_reg || step;
    assign accept       = req.valid && req.ready;
    assign in_vld_next  = accept || (in_vld_reg && !step);
    assign out_vld_next = step || (out_vld_reg && !rsp.ready);

    icds_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .freq_load (freq_load)
    );

    icds_core #(
        .THREADS (THREADS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_reg),
        .cfg       (cfg),
        .freq_load (freq_load),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= req.data;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

    a_phase_cmd_main: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.phase_change
        |-> out_reg.set_valid && (out_reg.set_thread == '0))
        else $error("phase change without main-thread command");

    a_no_cmd_thread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.set_valid |-> out_reg.set_thread == '0)
        else $error("set_thread nonzero without command");

    a_no_phase_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.phase_change |-> out_reg.phase_addr == '0)
        else $error("phase_addr nonzero without phase change");

    a_empty_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> req.ready)
        else $error("input stage empty but not ready");

    a_result_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_vld_reg)
        else $error("processed item produced no result");

endmodule
